[src/pesh_pkg.sv]
// ----------------------------------------------------------------------------
// pesh_pkg
// Shared types and codes for the periodic event scheduler heap
// ----------------------------------------------------------------------------
package pesh_pkg;

	localparam int DueW = 48;
	localparam int IdW  = 16;
	localparam int PerW = 16;

	// request codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_NEXT  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// heap read address select
	localparam logic [1:0] RD_ROOT   = 2'd0;
	localparam logic [1:0] RD_PARENT = 2'd1;
	localparam logic [1:0] RD_LEFT   = 2'd2;
	localparam logic [1:0] RD_RIGHT  = 2'd3;

	// heap write data select
	localparam logic [1:0] WR_CUR   = 2'd0;
	localparam logic [1:0] WR_RDATA = 2'd1;
	localparam logic [1:0] WR_CHILD = 2'd2;

	typedef struct packed {
		logic [DueW-1:0] due;
		logic [IdW-1:0]  id;
		logic [PerW-1:0] period;
	} pesh_entry_t;

	typedef struct packed {
		logic       load_add;
		logic       clear;
		logic       res_ld;
		logic [1:0] res_status;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       take_top;
		logic       take_left;
		logic       take_right;
		logic       pos_up;
		logic       pos_down;
		logic       out_ld;
	} pesh_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic pos_zero;
		logic left_in;
		logic right_in;
		logic cur_lt_rd;
		logic rd_lt_child;
		logic child_lt_cur;
	} pesh_sts_t;

	// heap order: due time, then id, then period
	function automatic logic pesh_before(pesh_entry_t a, pesh_entry_t b);
		logic [DueW+IdW+PerW-1:0] ka;
		logic [DueW+IdW+PerW-1:0] kb;
		ka = {a.due, a.id, a.period};
		kb = {b.due, b.id, b.period};
		return ka < kb;
	endfunction

endpackage

[src/pesh_datapath.sv]
// ----------------------------------------------------------------------------
// pesh_datapath
// Heap memory, entry count, hole position, compare logic and result registers
// ----------------------------------------------------------------------------
module pesh_datapath
	import pesh_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pesh_cmd_t       cmd,
	output pesh_sts_t       sts,
	input  logic [IdW-1:0]  entry_id,
	input  logic [PerW-1:0] period,
	output logic [IdW-1:0]  out_id,
	output logic [DueW-1:0] due_time,
	output logic [1:0]      status
);

	localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;

	pesh_entry_t     mem_q [CAPACITY];
	pesh_entry_t     rdata_q;
	pesh_entry_t     cur_q;
	pesh_entry_t     child_q;
	pesh_entry_t     wr_data;
	pesh_entry_t     top_next;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   child_addr_q;
	logic [AW-1:0]   pos_m1;
	logic [AW-1:0]   parent;
	logic [AW-1:0]   rd_addr;
	logic [CW-1:0]   count_q;
	logic [LW-1:0]   left_w;
	logic [LW-1:0]   right_w;
	logic [LW-1:0]   count_w;
	logic [DueW:0]   due_sum;
	logic [IdW-1:0]  res_id_q;
	logic [DueW-1:0] res_due_q;
	logic [1:0]      res_status_q;
	logic [IdW-1:0]  out_id_q;
	logic [DueW-1:0] out_due_q;
	logic [1:0]      out_status_q;

	assign pos_m1  = pos_q - AW'(1);
	assign parent  = pos_m1 >> 1;
	assign left_w  = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + LW'(1);
	assign count_w = LW'(count_q);

	// saturating advance of the root due time
	assign due_sum = {1'b0, rdata_q.due} + (DueW+1)'(rdata_q.period);
	always_comb begin
		top_next.id     = rdata_q.id;
		top_next.period = rdata_q.period;
		top_next.due    = due_sum[DueW] ? {DueW{1'b1}} : due_sum[DueW-1:0];
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ROOT:   rd_addr = '0;
			RD_PARENT: rd_addr = parent;
			RD_LEFT:   rd_addr = left_w[AW-1:0];
			RD_RIGHT:  rd_addr = right_w[AW-1:0];
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_CUR:   wr_data = cur_q;
			WR_RDATA: wr_data = rdata_q;
			WR_CHILD: wr_data = child_q;
			default:  wr_data = cur_q;
		endcase
	end

	always_comb begin
		sts.count_zero   = (count_q == '0);
		sts.count_full   = (count_q == CW'(CAPACITY));
		sts.pos_zero     = (pos_q == '0);
		sts.left_in      = (left_w < count_w);
		sts.right_in     = (right_w < count_w);
		sts.cur_lt_rd    = pesh_before(cur_q, rdata_q);
		sts.rd_lt_child  = pesh_before(rdata_q, child_q);
		sts.child_lt_cur = pesh_before(child_q, cur_q);
	end

	// heap array, single port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.load_add) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_add) begin
			cur_q.due    <= DueW'(period);
			cur_q.id     <= entry_id;
			cur_q.period <= period;
			pos_q        <= count_q[AW-1:0];
		end else if (cmd.take_top) begin
			cur_q <= top_next;
			pos_q <= '0;
		end else if (cmd.pos_up) begin
			pos_q <= parent;
		end else if (cmd.pos_down) begin
			pos_q <= child_addr_q;
		end
		if (cmd.take_left) begin
			child_q      <= rdata_q;
			child_addr_q <= left_w[AW-1:0];
		end else if (cmd.take_right) begin
			child_q      <= rdata_q;
			child_addr_q <= right_w[AW-1:0];
		end
		if (cmd.res_ld) begin
			res_id_q     <= '0;
			res_due_q    <= '0;
			res_status_q <= cmd.res_status;
		end else if (cmd.take_top) begin
			res_id_q  <= rdata_q.id;
			res_due_q <= rdata_q.due;
		end
		if (cmd.out_ld) begin
			out_id_q     <= res_id_q;
			out_due_q    <= res_due_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_id   = out_id_q;
	assign due_time = out_due_q;
	assign status   = out_status_q;

`ifndef ASSERT_OFF
	a_wr_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (LW'(pos_q) < count_w))
		else $error("heap write outside live entries");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_add |=> (count_q <= CW'(CAPACITY)) && (count_q != '0))
		else $error("entry count past capacity");
`endif

endmodule

[src/pesh_ctrl.sv]
// ----------------------------------------------------------------------------
// pesh_ctrl
// Sequencer for add (sift up), next (sift down) and clear requests
// ----------------------------------------------------------------------------
module pesh_ctrl
	import pesh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	output logic       out_valid,
	input  logic       out_stall,
	output pesh_cmd_t  cmd,
	input  pesh_sts_t  sts
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP_CHK = 4'd1;
	localparam logic [3:0] S_UP_CMP = 4'd2;
	localparam logic [3:0] S_NX_TOP = 4'd3;
	localparam logic [3:0] S_DN_CHK = 4'd4;
	localparam logic [3:0] S_DN_L   = 4'd5;
	localparam logic [3:0] S_DN_R   = 4'd6;
	localparam logic [3:0] S_DN_CMP = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func)
						FUNC_CLEAR: begin
							cmd.clear = 1'b1;
						end
						FUNC_ADD: begin
							cmd.res_ld = 1'b1;
							if (sts.count_full) begin
								cmd.res_status = STATUS_FULL;
								state_d        = S_FIN;
							end else begin
								cmd.res_status = STATUS_OK;
								cmd.load_add   = 1'b1;
								state_d        = S_UP_CHK;
							end
						end
						FUNC_NEXT: begin
							cmd.res_ld = 1'b1;
							if (sts.count_zero) begin
								cmd.res_status = STATUS_EMPTY;
								state_d        = S_FIN;
							end else begin
								cmd.res_status = STATUS_OK;
								cmd.rd_en      = 1'b1;
								cmd.rd_sel     = RD_ROOT;
								state_d        = S_NX_TOP;
							end
						end
						default: ;
					endcase
				end
			end
			S_UP_CHK: begin
				if (sts.pos_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_CUR;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.cur_lt_rd) begin
					// parent moves down into the hole
					cmd.wr_sel = WR_RDATA;
					cmd.pos_up = 1'b1;
					state_d    = S_UP_CHK;
				end else begin
					cmd.wr_sel = WR_CUR;
					state_d    = S_FIN;
				end
			end
			S_NX_TOP: begin
				cmd.take_top = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (!sts.left_in) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_CUR;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
					state_d    = S_DN_L;
				end
			end
			S_DN_L: begin
				cmd.take_left = 1'b1;
				if (sts.right_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
					state_d    = S_DN_R;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_R: begin
				// right wins only when strictly smaller
				cmd.take_right = sts.rd_lt_child;
				state_d        = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.child_lt_cur) begin
					cmd.wr_sel   = WR_CHILD;
					cmd.pos_down = 1'b1;
					state_d      = S_DN_CHK;
				end else begin
					cmd.wr_sel = WR_CUR;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_beat_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result beat raised outside finish");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_ADD || func == FUNC_NEXT)) |=> state_q != S_IDLE)
		else $error("add or next request dropped");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !cmd.rd_en)
		else $error("heap read and write in one cycle");
`endif

endmodule

[src/periodic_event_scheduler_heap_unit.sv]
// ----------------------------------------------------------------------------
// periodic_event_scheduler_heap_unit
// Min-heap of periodic registrations: add, issue next due entry, clear
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------
//  request | in_valid / in_stall | func, entry_id, period
//  result  | out_valid/out_stall | out_id, due_time, status
//
//  steps from accept to result load, one heap access at a time on the
//  single-port memory: clear is done at accept; add on a full store or next
//  on an empty one goes straight to the result; add reads the parent per
//  level climbed and writes the hole; next reads the root, then the left and
//  right child per level sunk; no result beat for clear or for unused func codes
//  arst_n empties the store; no clearing pass, entries past the count are
//  never read; a stalled result beat holds while the next request runs
// ----------------------------------------------------------------------------
module periodic_event_scheduler_heap_unit
	import pesh_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      func,
	input  logic [IdW-1:0]  entry_id,
	input  logic [PerW-1:0] period,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [IdW-1:0]  out_id,
	output logic [DueW-1:0] due_time,
	output logic [1:0]      status
);

	pesh_cmd_t cmd;
	pesh_sts_t sts;

	pesh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	pesh_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.entry_id (entry_id),
		.period   (period),
		.out_id   (out_id),
		.due_time (due_time),
		.status   (status)
	);

endmodule

[sim/periodic_event_scheduler_heap_unit_tb.sv]
// ----------------------------------------------------------------------------
// periodic_event_scheduler_heap_unit_tb
// Self-checking bench for the periodic event scheduler min-heap
// ----------------------------------------------------------------------------
//  A heap model inside the bench tracks every accepted request and predicts
//  the reply beat for add and next. Directed requests cover the empty store,
//  zero periods, ties broken by period and the unused request code. Random
//  add/next/clear traffic follows, with ids and periods often narrowed to
//  force ties. Of three phases, the first two throttle both channels.
// ----------------------------------------------------------------------------
module periodic_event_scheduler_heap_unit_tb;
	import pesh_pkg::*;

	localparam int HeapCap = 1024;
	localparam int RunLimit = 1000000;
	localparam int TailCycles = 60;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [IdW-1:0]  id;
		logic [DueW-1:0] due;
		logic [1:0]      st;
	} sched_reply_t;

	class due_order_book;
		logic [DueW-1:0] due_q [HeapCap];
		logic [IdW-1:0]  id_q  [HeapCap];
		logic [PerW-1:0] per_q [HeapCap];
		int fill;
		sched_reply_t awaited [$];
		int errors;
		int n_issued, n_added, n_empty, n_full, n_clear, deepest;

		function new();
			fill = 0;
			errors = 0;
			n_issued = 0;
			n_added = 0;
			n_empty = 0;
			n_full = 0;
			n_clear = 0;
			deepest = 0;
		endfunction

		// due time, then id, then period
		function bit earlier(int a, int b);
			if (due_q[a] != due_q[b]) return due_q[a] < due_q[b];
			if (id_q[a] != id_q[b]) return id_q[a] < id_q[b];
			return per_q[a] < per_q[b];
		endfunction

		function void swap_entries(int a, int b);
			logic [DueW-1:0] d;
			logic [IdW-1:0]  i;
			logic [PerW-1:0] p;
			d = due_q[a]; i = id_q[a]; p = per_q[a];
			due_q[a] = due_q[b]; id_q[a] = id_q[b]; per_q[a] = per_q[b];
			due_q[b] = d; id_q[b] = i; per_q[b] = p;
		endfunction

		function void climb(int pos);
			int up;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (!earlier(pos, up)) break;
				swap_entries(pos, up);
				pos = up;
			end
		endfunction

		function void sink(int pos);
			int lc;
			int best;
			forever begin
				lc = 2 * pos + 1;
				best = pos;
				if (lc < fill && earlier(lc, best)) best = lc;
				if (lc + 1 < fill && earlier(lc + 1, best)) best = lc + 1;
				if (best == pos) break;
				swap_entries(pos, best);
				pos = best;
			end
		endfunction

		function void note_request(logic [1:0] f, logic [IdW-1:0] i, logic [PerW-1:0] p);
			sched_reply_t r;
			logic [DueW:0] sum;
			r.id = '0;
			r.due = '0;
			r.st = STATUS_OK;
			case (f)
				FUNC_CLEAR: begin
					fill = 0;
					n_clear++;
				end
				FUNC_ADD: begin
					if (fill >= HeapCap) begin
						r.st = STATUS_FULL;
						n_full++;
					end else begin
						id_q[fill] = i;
						per_q[fill] = p;
						due_q[fill] = DueW'(p);
						fill++;
						climb(fill - 1);
						n_added++;
						if (fill > deepest) deepest = fill;
					end
					awaited.push_back(r);
				end
				FUNC_NEXT: begin
					if (fill == 0) begin
						r.st = STATUS_EMPTY;
						n_empty++;
					end else begin
						r.id = id_q[0];
						r.due = due_q[0];
						sum = {1'b0, due_q[0]} + (DueW+1)'(per_q[0]);
						due_q[0] = sum[DueW] ? {DueW{1'b1}} : sum[DueW-1:0];
						sink(0);
						n_issued++;
					end
					awaited.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [IdW-1:0] i, logic [DueW-1:0] d, logic [1:0] s);
			sched_reply_t r;
			if (awaited.size() == 0) begin
				$error("reply beat with none awaited: out_id %0d due_time %0d status %0d",
					i, d, s);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (s !== r.st) begin
				$error("status mismatch: expected %0d, actual %0d", r.st, s);
				errors++;
			end
			if (i !== r.id) begin
				$error("out_id mismatch: expected %0d, actual %0d", r.id, i);
				errors++;
			end
			if (d !== r.due) begin
				$error("due_time mismatch: expected %0d, actual %0d", r.due, d);
				errors++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [1:0]      func;
	logic [IdW-1:0]  entry_id;
	logic [PerW-1:0] period;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [IdW-1:0]  out_id;
	logic [DueW-1:0] due_time;
	logic [1:0]      status;

	due_order_book book;
	int send_idle = 0;
	int recv_idle = 0;
	int cycles = 0;

	periodic_event_scheduler_heap_unit #(
		.CAPACITY(HeapCap)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.entry_id(entry_id),
		.period(period),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_id(out_id),
		.due_time(due_time),
		.status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) book.check_result(out_id, due_time, status);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RunLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// entered just after the clock rises; returns once the unit has taken the request
	task send_request(logic [1:0] f, logic [IdW-1:0] i, logic [PerW-1:0] p);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_id <= i;
		period <= p;
		do @(posedge clk); while (in_stall);
		book.note_request(f, i, p);
	endtask

	function logic [IdW-1:0] pick_id();
		return ($urandom_range(3) == 0) ? IdW'($urandom_range(7)) : IdW'($urandom);
	endfunction

	function logic [PerW-1:0] pick_period();
		return ($urandom_range(3) == 0) ? PerW'($urandom_range(4)) : PerW'($urandom);
	endfunction

	task random_traffic(int count);
		int done;
		int roll;
		logic [1:0] f;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(99);
			if (roll < 4) f = FUNC_CLEAR;
			else if (roll < 8) f = FUNC_UNUSED;
			else if (roll < 54) f = FUNC_ADD;
			else f = FUNC_NEXT;
			send_request(f, pick_id(), pick_period());
			if (f != FUNC_UNUSED) done++;
		end
	endtask

	task directed_requests();
		send_request(FUNC_NEXT, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_UNUSED, 16'h1234, 16'h0001);
		send_request(FUNC_ADD, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_ADD, 16'h0000, 16'h0001);
		send_request(FUNC_ADD, 16'h0007, 16'h0000);
		// zero period stays due at zero
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_CLEAR, 16'hFFFF, 16'hFFFF);
		// same id, periods 6 and 3 meet at due 6: smaller period first
		send_request(FUNC_ADD, 16'h0005, 16'h0006);
		send_request(FUNC_ADD, 16'h0005, 16'h0003);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_ADD, 16'hFFFF, 16'h0001);
		send_request(FUNC_ADD, 16'h0000, 16'hFFFF);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_CLEAR, '0, '0);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_ADD, 16'h8000, 16'h8000);
		send_request(FUNC_NEXT, '0, '0);
		send_request(FUNC_CLEAR, '0, '0);
	endtask

	initial begin
		book = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_CLEAR;
		entry_id = '0;
		period = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 26;
		recv_idle = 69;
		directed_requests();
		random_traffic(160);

		send_idle = 69;
		recv_idle = 26;
		random_traffic(160);

		send_idle = 0;
		recv_idle = 0;
		random_traffic(160);
		in_valid <= 1'b0;

		while (book.awaited.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d adds, %0d issued entries, %0d clears, deepest store %0d entries",
			book.n_added, book.n_issued, book.n_clear, book.deepest);
		$display("status replies: %0d empty-store, %0d full-store; %0d cycles",
			book.n_empty, book.n_full, cycles);
		if (book.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
src/pesh_pkg.sv
src/pesh_datapath.sv
src/pesh_ctrl.sv
src/periodic_event_scheduler_heap_unit.sv
sim/periodic_event_scheduler_heap_unit_tb.sv
